// File: rtl/rmcp_pkg.sv
`timescale 1ns / 1ps
// Types, codes and the fixed group map of the register map cache proxy.
// Used by register_map_cache_proxy; depends on nothing else.

package rmcp_pkg;

	localparam int GROUP_COUNT    = 13;
	localparam int MAX_READ_WORDS = 64;
	localparam int OP_W           = 3;
	localparam int S_DATA_W       = 128;
	localparam int M_DATA_W       = 56;

	localparam logic [15:0] NAN_WORD  = 16'hFFFF;
	localparam logic [7:0]  SOC_UNKNOWN = 8'd255;

	typedef enum logic [OP_W-1:0] {
		OP_INVAL = 3'd0,
		OP_POLL  = 3'd1,
		OP_DONE  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		SYN_CACHED,
		SYN_GRID,
		SYN_SOC,
		SYN_CHARGE,
		SYN_DISCHARGE
	} synth_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POLL,
		ST_LOOK,
		ST_FETCH,
		ST_FORM
	} state_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [3:0]  len;
		logic [7:0]  unit;
		logic [5:0]  base;
		synth_t      synth;
	} grp_t;

	localparam grp_t GRP_TAB [GROUP_COUNT] = '{
		'{16'd30513, 4'd4,  8'd3, 6'd0,  SYN_CACHED},
		'{16'd30773, 4'd2,  8'd3, 6'd4,  SYN_CACHED},
		'{16'd30775, 4'd2,  8'd0, 6'd0,  SYN_GRID},
		'{16'd30845, 4'd2,  8'd0, 6'd0,  SYN_SOC},
		'{16'd30961, 4'd2,  8'd3, 6'd6,  SYN_CACHED},
		'{16'd30967, 4'd2,  8'd3, 6'd8,  SYN_CACHED},
		'{16'd31393, 4'd2,  8'd0, 6'd0,  SYN_CHARGE},
		'{16'd31395, 4'd2,  8'd0, 6'd0,  SYN_DISCHARGE},
		'{16'd31401, 4'd4,  8'd3, 6'd10, SYN_CACHED},
		'{16'd30581, 4'd4,  8'd2, 6'd14, SYN_CACHED},
		'{16'd30865, 4'd8,  8'd2, 6'd18, SYN_CACHED},
		'{16'd31259, 4'd10, 8'd2, 6'd26, SYN_CACHED},
		'{16'd31435, 4'd6,  8'd2, 6'd36, SYN_CACHED}
	};

	// input transfer payload, last field in the lowest bits
	typedef struct packed {
		logic [5:0]         pad;
		logic signed [31:0] battery_power;
		logic [7:0]         charge_percent;
		logic signed [31:0] grid_power;
		logic [6:0]         read_count;
		logic [15:0]        start_address;
		logic [15:0]        cache_data;
		logic [5:0]         write_slot;
		logic               success;
		logic [3:0]         group_index;
	} in_t;

	// result transfer payload without last_word, last field in the lowest bits
	typedef struct packed {
		logic [15:0] read_data;
		logic [5:0]  poll_cache_base;
		logic [3:0]  poll_length;
		logic [15:0] poll_address;
		logic [7:0]  poll_unit;
		logic [3:0]  poll_group;
		logic        poll_granted;
	} out_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] grp;
		logic [3:0] off;
	} lk_t;

	// address decode against the group map; the first matching group wins
	function automatic lk_t lookup(input logic [15:0] a);
		lk_t         r;
		logic [15:0] d;
		r = '{hit: 1'b0, grp: 4'(GROUP_COUNT), off: 4'd0};
		for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
			d = a - GRP_TAB[i].addr;
			if (d < {12'd0, GRP_TAB[i].len}) begin
				r.hit = 1'b1;
				r.grp = 4'(i);
				r.off = d[3:0];
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/register_map_cache_proxy.sv
`timescale 1ns / 1ps
// Register map cache proxy: 13-group register map served from a word cache.
// Depends on rmcp_pkg for the group map, codes and payload layouts.
//
// Usage: items enter on the s_ channel (s_tuser carries the operation code),
// results leave on the m_ channel (m_tlast marks the final word of a read).
// Invalidate, poll done and cache write finish in the transfer cycle and
// give no result. A poll request walks the round-robin pointer one group
// per cycle past synthesized groups and gives a single result. A read
// returns one word per address; each word passes through address decode,
// registered cache read and word assembly in turn. s_tready is high only
// while no item is in progress; the output register lets a new item in
// while the last result still waits. When the receiver stalls, the word in
// the output register holds and the sequencer waits before loading the next.
// Reset clears fresh bits, the pending flag, the pointer and the valid bit
// of every cache word, so unwritten words read as zero; no clearing pass.

module register_map_cache_proxy #(
	parameter int CACHE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// group_index, success, write_slot, cache_data, start_address,
	// read_count, grid_power, charge_percent, battery_power, zero fill
	input  logic [rmcp_pkg::S_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [rmcp_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// poll_granted, poll_group, poll_unit, poll_address, poll_length,
	// poll_cache_base, read_data, zero fill
	output logic [rmcp_pkg::M_DATA_W-1:0]  m_tdata,
	// last_word
	output logic                           m_tlast
);
	import rmcp_pkg::*;

	localparam int CW = $clog2(CACHE_DEPTH);

	in_t    in_w;
	state_t state_q, state_d;

	logic [GROUP_COUNT-1:0] fresh_q;
	logic                   pending_q;
	logic [3:0]             rr_q;
	logic [15:0]            addr_q;
	logic [6:0]             remain_q;
	logic [31:0]            grid_q;
	logic [7:0]             soc_q;
	logic [31:0]            chg_q;
	logic [31:0]            dis_q;
	lk_t                    lk_q;

	logic [15:0]            mem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] valid_q;
	logic [15:0]            rdata_q;
	logic                   rvalid_q;
	logic [6:0]             rd_sum;
	logic [CW-1:0]          rd_idx;
	logic [CW-1:0]          wr_idx;
	logic                   wr_en;

	logic                   out_valid_q;
	out_t                   out_q;
	out_t                   out_d;
	logic                   out_last_q;

	logic                   acc;
	logic                   out_free;
	logic [3:0]             g_sel;
	logic [3:0]             g_next;
	logic                   poll_load;
	logic                   poll_grant;
	logic                   rr_adv;
	logic                   word_load;
	logic [15:0]            word;
	logic [6:0]             n_words;
	grp_t                   lk_grp;
	grp_t                   poll_grp;

	assign in_w     = in_t'(s_tdata);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign n_words  = (in_w.read_count > 7'(MAX_READ_WORDS)) ?
		7'(MAX_READ_WORDS) : in_w.read_count;

	assign g_sel    = (rr_q < 4'(GROUP_COUNT)) ? rr_q : 4'd0;
	assign g_next   = (g_sel == 4'(GROUP_COUNT - 1)) ? 4'd0 : g_sel + 4'd1;
	assign poll_grp = GRP_TAB[g_sel];
	assign lk_grp   = lk_q.hit ? GRP_TAB[lk_q.grp] : GRP_TAB[0];

	assign wr_en  = acc && (s_tuser == OP_WRITE) && (int'(in_w.write_slot) < CACHE_DEPTH);
	assign wr_idx = CW'(in_w.write_slot);
	assign rd_sum = {1'b0, lk_grp.base} + {3'd0, lk_q.off};
	// wrap a group that runs past the end of a small cache back to the cache start
	assign rd_idx = (int'(rd_sum) >= CACHE_DEPTH) ? CW'(int'(rd_sum) - CACHE_DEPTH) :
		CW'(rd_sum);

	// word assembly for the decoded address
	always_comb begin
		word = NAN_WORD;
		if (lk_q.hit) begin
			case (lk_grp.synth)
				SYN_CACHED: begin
					if (fresh_q[lk_q.grp])
						word = rvalid_q ? rdata_q : 16'd0;
				end
				SYN_GRID: word = lk_q.off[0] ? grid_q[15:0] : grid_q[31:16];
				SYN_SOC: begin
					if (soc_q != SOC_UNKNOWN)
						word = lk_q.off[0] ? {8'd0, soc_q} : 16'd0;
				end
				SYN_CHARGE: word = lk_q.off[0] ? chg_q[15:0] : chg_q[31:16];
				SYN_DISCHARGE: word = lk_q.off[0] ? dis_q[15:0] : dis_q[31:16];
				default: word = NAN_WORD;
			endcase
		end
	end

	// sequencer outputs
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		poll_load  = 1'b0;
		poll_grant = 1'b0;
		rr_adv     = 1'b0;
		word_load  = 1'b0;
		case (state_q)
			ST_POLL: begin
				if (pending_q) begin
					poll_load = out_free;
				end else if (poll_grp.synth != SYN_CACHED) begin
					rr_adv = 1'b1;
				end else begin
					poll_load  = out_free;
					poll_grant = 1'b1;
					rr_adv     = out_free;
				end
			end
			ST_FORM: word_load = out_free;
			default: ;
		endcase
	end

	// next result payload for a poll or a read word
	always_comb begin
		out_d = '0;
		if (poll_grant) begin
			out_d.poll_granted    = 1'b1;
			out_d.poll_group      = g_sel;
			out_d.poll_unit       = poll_grp.unit;
			out_d.poll_address    = poll_grp.addr;
			out_d.poll_length     = poll_grp.len;
			out_d.poll_cache_base = poll_grp.base;
		end
		if (word_load)
			out_d.read_data = word;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (s_tuser == OP_POLL)
						state_d = ST_POLL;
					else if (s_tuser == OP_READ && n_words != 7'd0)
						state_d = ST_LOOK;
				end
			end
			ST_POLL: begin
				if (poll_load)
					state_d = ST_IDLE;
			end
			ST_LOOK:  state_d = ST_FETCH;
			ST_FETCH: state_d = ST_FORM;
			ST_FORM: begin
				if (word_load)
					state_d = (remain_q == 7'd1) ? ST_IDLE : ST_LOOK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fresh_q     <= '0;
			pending_q   <= 1'b0;
			rr_q        <= 4'd0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
			if (acc) begin
				case (s_tuser)
					OP_INVAL: begin
						fresh_q   <= '0;
						pending_q <= 1'b0;
					end
					OP_DONE: begin
						pending_q <= 1'b0;
						if (in_w.success && in_w.group_index < 4'(GROUP_COUNT))
							fresh_q[in_w.group_index[3:0]] <= 1'b1;
					end
					default: ;
				endcase
			end
			if (rr_adv)
				rr_q <= g_next;
			if (poll_load && poll_grant)
				pending_q <= 1'b1;
			if (poll_load || word_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload and read context
	always_ff @(posedge clk) begin
		if (acc && s_tuser == OP_READ) begin
			addr_q   <= in_w.start_address;
			remain_q <= n_words;
			grid_q   <= in_w.grid_power;
			soc_q    <= in_w.charge_percent;
			chg_q    <= in_w.battery_power[31] ? 32'd0 - in_w.battery_power : 32'd0;
			dis_q    <= in_w.battery_power[31] ? 32'd0 : in_w.battery_power;
		end
		if (state_q == ST_LOOK)
			lk_q <= lookup(addr_q);
		if (word_load) begin
			addr_q   <= addr_q + 16'd1;
			remain_q <= remain_q - 7'd1;
		end
		if (poll_load || word_load) begin
			out_q      <= out_d;
			out_last_q <= word_load && (remain_q == 7'd1);
		end
	end

	// cache memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= in_w.cache_data;
		rdata_q  <= mem[rd_idx];
		rvalid_q <= valid_q[rd_idx];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};
	assign m_tlast  = out_last_q;

	a_pending_from_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> (m_tvalid && out_q.poll_granted))
		else $error("pending flag set without a granted poll result");

	a_poll_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.poll_granted) |-> !m_tlast)
		else $error("granted poll result marked as last word");

	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rr_q < 4'(GROUP_COUNT))
		else $error("round-robin pointer out of range");

	a_read_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK || state_q == ST_FETCH || state_q == ST_FORM) |->
		remain_q != 7'd0)
		else $error("read sequence running with no words left");

endmodule

// File: test/register_map_cache_proxy_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for register_map_cache_proxy: directed and random polls, cache
// writes and reads, each result checked against a predictor of the register map.
// Depends on rmcp_pkg and the register_map_cache_proxy RTL.

module register_map_cache_proxy_tb;
	import rmcp_pkg::*;

	localparam int CACHE_WORDS = 64;
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [15:0] addr;
		logic [3:0]  len;
		logic [7:0]  unit;
		logic [5:0]  base;
		synth_t      kind;
	} grp_row_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  group;
		logic [7:0]  unit;
		logic [15:0] address;
		logic [3:0]  length;
		logic [5:0]  cache_base;
		logic [15:0] data;
		logic        last;
	} reply_t;

	typedef struct packed {
		logic [2:0] op;
		in_t        data;
	} stim_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]     s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	register_map_cache_proxy DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// predictor state
	logic [15:0]            cache_mirror [CACHE_WORDS] = '{default: '0};
	logic [GROUP_COUNT-1:0] fresh_flags = '0;
	bit                     poll_busy = 1'b0;
	logic [3:0]             rr_next = '0;

	reply_t reply_queue [$];
	stim_t  pending_items [$];
	int     mismatch_count = 0;

	// stimulus-side view of the round-robin, used only to build fetch sequences
	int gen_rr = 0;
	bit gen_pending = 1'b0;
	int gen_group = 0;

	int send_wait = 0;
	int recv_wait = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic grp_row_t group_row(input int g);
		grp_row_t r;
		case (g)
		0:  r = '{16'd30513, 4'd4,  8'd3, 6'd0,  SYN_CACHED};
		1:  r = '{16'd30773, 4'd2,  8'd3, 6'd4,  SYN_CACHED};
		2:  r = '{16'd30775, 4'd2,  8'd0, 6'd0,  SYN_GRID};
		3:  r = '{16'd30845, 4'd2,  8'd0, 6'd0,  SYN_SOC};
		4:  r = '{16'd30961, 4'd2,  8'd3, 6'd6,  SYN_CACHED};
		5:  r = '{16'd30967, 4'd2,  8'd3, 6'd8,  SYN_CACHED};
		6:  r = '{16'd31393, 4'd2,  8'd0, 6'd0,  SYN_CHARGE};
		7:  r = '{16'd31395, 4'd2,  8'd0, 6'd0,  SYN_DISCHARGE};
		8:  r = '{16'd31401, 4'd4,  8'd3, 6'd10, SYN_CACHED};
		9:  r = '{16'd30581, 4'd4,  8'd2, 6'd14, SYN_CACHED};
		10: r = '{16'd30865, 4'd8,  8'd2, 6'd18, SYN_CACHED};
		11: r = '{16'd31259, 4'd10, 8'd2, 6'd26, SYN_CACHED};
		default: r = '{16'd31435, 4'd6, 8'd2, 6'd36, SYN_CACHED};
		endcase
		return r;
	endfunction

	// one register word as seen at address a, live inputs taken from the read item
	function automatic logic [15:0] word_for(input logic [15:0] a, input in_t it);
		grp_row_t    row;
		int          hit;
		int          off;
		logic [31:0] v;
		logic [31:0] b;
		logic [15:0] w;
		hit = -1;
		for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
			row = group_row(g);
			if (int'(a) >= int'(row.addr) && int'(a) < int'(row.addr) + int'(row.len))
				hit = g;
		end
		if (hit < 0)
			return NAN_WORD;
		row = group_row(hit);
		off = int'(a) - int'(row.addr);
		b = it.battery_power;
		v = '0;
		case (row.kind)
		SYN_GRID:   v = it.grid_power;
		SYN_SOC:    v = {24'd0, it.charge_percent};
		SYN_CHARGE: v = b[31] ? (~b + 32'd1) : 32'd0;
		SYN_DISCHARGE: v = (b != 32'd0 && !b[31]) ? b : 32'd0;
		default: ;
		endcase
		w = (off % 2 == 1) ? v[15:0] : v[31:16];
		if (row.kind == SYN_CACHED)
			w = fresh_flags[hit] ? cache_mirror[(int'(row.base) + off) % CACHE_WORDS] : NAN_WORD;
		else if (row.kind == SYN_SOC && it.charge_percent == SOC_UNKNOWN)
			w = NAN_WORD;
		return w;
	endfunction

	// advance the mirrored proxy state by one accepted item and queue its results
	task automatic compute_replies(input logic [2:0] op, input in_t it);
		reply_t      r;
		grp_row_t    row;
		logic [3:0]  g;
		logic [15:0] addr;
		int          n;
		r = '0;
		case (op)
		OP_INVAL: begin
			fresh_flags = '0;
			poll_busy = 1'b0;
		end
		OP_POLL: begin
			for (int t = 0; t < GROUP_COUNT; t++) begin
				if (!poll_busy) begin
					g = (rr_next < GROUP_COUNT) ? rr_next : 4'd0;
					rr_next = (g == GROUP_COUNT - 1) ? 4'd0 : g + 4'd1;
					row = group_row(g);
					if (row.kind == SYN_CACHED) begin
						r.granted = 1'b1;
						r.group = g;
						r.unit = row.unit;
						r.address = row.addr;
						r.length = row.len;
						r.cache_base = row.base;
						poll_busy = 1'b1;
					end
				end
			end
			reply_queue.push_back(r);
		end
		OP_DONE: begin
			poll_busy = 1'b0;
			if (it.success && it.group_index < GROUP_COUNT)
				fresh_flags[it.group_index] = 1'b1;
		end
		OP_WRITE: cache_mirror[it.write_slot] = it.cache_data;
		OP_READ: begin
			n = (it.read_count > MAX_READ_WORDS) ? MAX_READ_WORDS : int'(it.read_count);
			for (int i = 0; i < n; i++) begin
				addr = it.start_address + 16'(i);
				r = '0;
				r.data = word_for(addr, it);
				r.last = (i == n - 1);
				reply_queue.push_back(r);
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// source side: present queued items, predict each on its transfer
	always @(posedge clk or negedge arst_n) begin : drive_items
		int    wait_left;
		stim_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				compute_replies(s_tuser, in_t'(s_tdata));
				if ($urandom_range(0, 29) == 0)
					send_quiet <= !send_quiet;
				wait_left = draw_gap(send_quiet);
			end else begin
				wait_left = send_wait;
			end
			if (wait_left == 0 && pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.op;
				s_tdata <= nxt.data;
			end else begin
				s_tvalid <= 1'b0;
				send_wait <= (wait_left > 0) ? wait_left - 1 : 0;
			end
		end
	end

	// sink side: random backpressure, compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_results
		reply_t want;
		out_t   got;
		int     gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			got = out_t'(m_tdata[$bits(out_t)-1:0]);
			if (reply_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: no result expected, actual data %0h last %0b",
					$time, m_tdata, m_tlast);
			end else begin
				want = reply_queue.pop_front();
				check_field("poll_granted", 32'(want.granted), 32'(got.poll_granted));
				check_field("poll_group", 32'(want.group), 32'(got.poll_group));
				check_field("poll_unit", 32'(want.unit), 32'(got.poll_unit));
				check_field("poll_address", 32'(want.address), 32'(got.poll_address));
				check_field("poll_length", 32'(want.length), 32'(got.poll_length));
				check_field("poll_cache_base", 32'(want.cache_base),
					32'(got.poll_cache_base));
				check_field("read_data", 32'(want.data), 32'(got.read_data));
				check_field("last_word", 32'(want.last), 32'(m_tlast));
			end
			if ($urandom_range(0, 29) == 0)
				recv_quiet <= !recv_quiet;
			gap = draw_gap(recv_quiet);
			m_tready <= (gap == 0);
			recv_wait <= (gap > 0) ? gap - 1 : 0;
		end else if (!m_tready) begin
			if (recv_wait > 0)
				recv_wait <= recv_wait - 1;
			else
				m_tready <= 1'b1;
		end
	end

	function automatic logic [31:0] pick_power();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'd0;
		3: return 32'hFFFF_FFFF;
		4: return $urandom_range(1, 5000);
		5: return 32'd0 - $urandom_range(1, 5000);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_charge();
		case ($urandom_range(0, 3))
		0: return SOC_UNKNOWN;
		1: return 8'($urandom_range(0, 100));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// every field but the pad random so that idle fields toggle too
	function automatic in_t noise_payload();
		in_t p;
		p.pad = '0;
		p.group_index = 4'($urandom_range(0, 15));
		p.success = 1'($urandom_range(0, 1));
		p.write_slot = 6'($urandom_range(0, 63));
		p.cache_data = 16'($urandom_range(0, 65535));
		p.start_address = 16'($urandom_range(0, 65535));
		p.read_count = 7'($urandom_range(0, MAX_READ_WORDS));
		p.grid_power = pick_power();
		p.charge_percent = pick_charge();
		p.battery_power = pick_power();
		return p;
	endfunction

	task automatic add_item(input logic [2:0] op, input in_t p);
		stim_t s;
		s.op = op;
		s.data = p;
		pending_items.push_back(s);
	endtask

	task automatic add_poll();
		grp_row_t row;
		for (int t = 0; t < GROUP_COUNT; t++) begin
			if (!gen_pending) begin
				row = group_row(gen_rr);
				if (row.kind == SYN_CACHED) begin
					gen_group = gen_rr;
					gen_pending = 1'b1;
				end
				gen_rr = (gen_rr + 1) % GROUP_COUNT;
			end
		end
		add_item(OP_POLL, noise_payload());
	endtask

	task automatic add_done(input int g, input bit ok);
		in_t p;
		p = noise_payload();
		p.group_index = 4'(g);
		p.success = ok;
		gen_pending = 1'b0;
		add_item(OP_DONE, p);
	endtask

	task automatic add_write(input int off, input logic [15:0] d);
		in_t p;
		p = noise_payload();
		p.write_slot = 6'(off);
		p.cache_data = d;
		add_item(OP_WRITE, p);
	endtask

	task automatic add_read(input logic [15:0] start, input int count,
			input logic [31:0] grid, input logic [7:0] charge, input logic [31:0] batt);
		in_t p;
		p = noise_payload();
		p.start_address = start;
		p.read_count = 7'(count);
		p.grid_power = grid;
		p.charge_percent = charge;
		p.battery_power = batt;
		add_item(OP_READ, p);
	endtask

	task automatic add_inval();
		gen_pending = 1'b0;
		add_item(OP_INVAL, noise_payload());
	endtask

	task automatic add_random_read();
		grp_row_t    row;
		logic [15:0] start;
		int          count;
		if ($urandom_range(0, 3) != 0) begin
			row = group_row($urandom_range(0, GROUP_COUNT - 1));
			start = row.addr + 16'($urandom_range(0, row.len)) - 16'($urandom_range(0, 2));
			count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_READ_WORDS)
				: $urandom_range(0, 12);
		end else begin
			start = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
				: 16'hFFF0 + 16'($urandom_range(0, 15));
			count = ($urandom_range(0, 7) == 0) ? MAX_READ_WORDS : $urandom_range(0, 8);
		end
		add_read(start, count, pick_power(), pick_charge(), pick_power());
	endtask

	// well-formed fetch: poll, fill the granted group, finish it, read it back
	task automatic add_fetch_round();
		grp_row_t row;
		add_poll();
		row = group_row(gen_group);
		for (int k = 0; k < row.len; k++)
			if ($urandom_range(0, 7) != 0)
				add_write(row.base + k, 16'($urandom_range(0, 65535)));
		add_done(gen_group, $urandom_range(0, 7) != 0);
		repeat ($urandom_range(1, 2))
			add_read(row.addr - 16'($urandom_range(0, 2)), row.len + $urandom_range(0, 4),
				pick_power(), pick_charge(), pick_power());
	endtask

	initial begin
		// directed: reset contents, extremes, pending poll, bad indexes, spare codes
		add_read(16'd30513, MAX_READ_WORDS, 32'h8000_0000, SOC_UNKNOWN, 32'h8000_0000);
		add_read(16'hFFFE, 4, 32'h7FFF_FFFF, 8'd0, 32'h7FFF_FFFF);
		add_read(16'd30775, 0, 32'd5, 8'd50, 32'd5);
		add_read(16'd0, 1, 32'd0, 8'd0, 32'd0);
		add_poll();
		add_poll();
		add_write(0, 16'hFFFF);
		add_write(63, 16'h0000);
		add_write(1, 16'h1234);
		add_write(2, 16'h8000);
		add_write(3, 16'h00FF);
		add_done(0, 1'b1);
		add_read(16'd30511, 8, 32'hFFFF_FFFF, 8'd100, 32'hFFFF_FFFF);
		add_poll();
		add_done(15, 1'b1);
		add_poll();
		add_done(13, 1'b1);
		add_poll();
		add_done(5, 1'b0);
		add_item(OP_SPARE_5, noise_payload());
		add_item(OP_SPARE_7, noise_payload());
		add_read(16'd30773, 4, 32'd1234, 8'd55, 32'd0);
		add_read(16'd31393, 4, 32'd0, SOC_UNKNOWN, 32'hFFFF_FFFF);
		add_inval();
		add_read(16'd30513, 2, 32'd0, 8'd0, 32'd0);

		while (pending_items.size() < 320) begin
			case ($urandom_range(0, 11))
			0, 1, 2, 3, 4: add_fetch_round();
			5, 6, 7: add_random_read();
			8: add_write($urandom_range(0, 63), 16'($urandom_range(0, 65535)));
			9: add_poll();
			10: add_done($urandom_range(0, 15), 1'($urandom_range(0, 1)));
			default: begin
				if ($urandom_range(0, 2) == 0)
					add_inval();
				else
					add_random_read();
			end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && reply_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
